// ===== design/twrt_pkg.sv =====
// Shared types, constants and helpers of the tile window residency tracker.
// No dependencies.
package twrt_pkg;

  localparam int LEDGER_ENTRIES = 64;
  localparam int IDX_W          = $clog2(LEDGER_ENTRIES);
  localparam int CNT_W          = $clog2(LEDGER_ENTRIES + 1);
  localparam int RADIUS_MAX     = 3;

  localparam logic [3:0] CMD_SET_FOCUS    = 4'd0;
  localparam logic [3:0] CMD_READ_FOCUS   = 4'd1;
  localparam logic [3:0] CMD_IS_ACTIVE    = 4'd2;
  localparam logic [3:0] CMD_IS_LOADED    = 4'd3;
  localparam logic [3:0] CMD_MARK_LOADED  = 4'd4;
  localparam logic [3:0] CMD_MARK_UNLOAD  = 4'd5;
  localparam logic [3:0] CMD_INVALIDATE   = 4'd6;
  localparam logic [3:0] CMD_LIST_LOAD    = 4'd7;
  localparam logic [3:0] CMD_LIST_UNLOAD  = 4'd8;
  localparam logic [3:0] CMD_LIST_REBUILD = 4'd9;
  localparam logic [3:0] CMD_CLEAR        = 4'd10;

  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_OUTSIDE    = 2'd1;
  localparam logic [1:0] ST_NOT_LOADED = 2'd2;
  localparam logic [1:0] ST_FULL       = 2'd3;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_CLEAR,
    OP_INSERT,
    OP_REMOVE,
    OP_ROTATE,
    OP_SET_LD,
    OP_SET_RB
  } cell_op_t;

  typedef struct packed {
    logic        vld;
    logic        ld;
    logic        rb;
    logic [31:0] x;
    logic [31:0] z;
  } entry_t;

  // signed (x, z) ordering: x first, then z
  function automatic logic key_less(input logic [31:0] ax, input logic [31:0] az,
                                    input logic [31:0] bx, input logic [31:0] bz);
    logic [63:0] a;
    logic [63:0] b;
    a = {~ax[31], ax[30:0], ~az[31], az[30:0]};
    b = {~bx[31], bx[30:0], ~bz[31], bz[30:0]};
    return a < b;
  endfunction

  // window test at full precision, no wrap
  function automatic logic tile_active(input logic [31:0] x, input logic [31:0] z,
                                       input logic [31:0] fx, input logic [31:0] fz,
                                       input logic [1:0] r);
    logic signed [32:0] dx;
    logic signed [32:0] dz;
    logic signed [32:0] rr;
    dx = $signed({x[31], x}) - $signed({fx[31], fx});
    dz = $signed({z[31], z}) - $signed({fz[31], fz});
    rr = $signed({31'd0, r});
    return (dx >= -rr) && (dx <= rr) && (dz >= -rr) && (dz <= rr);
  endfunction

endpackage

// ===== design/twrt_ifs.sv =====
// Channel interfaces of the tile window residency tracker.
// Depends on nothing but the port widths.
interface twrt_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  cmd;
  logic [31:0] tile_x;
  logic [31:0] tile_z;
  modport source (output valid, cmd, tile_x, tile_z, input ready);
  modport sink   (input valid, cmd, tile_x, tile_z, output ready);
endinterface

interface twrt_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        answer;
  logic [31:0] out_x;
  logic [31:0] out_z;
  logic        item_valid;
  logic        last;
  logic [6:0]  loaded_tiles;
  modport source (output valid, status, answer, out_x, out_z, item_valid, last,
                  loaded_tiles, input ready);
  modport sink   (input valid, status, answer, out_x, out_z, item_valid, last,
                  loaded_tiles, output ready);
endinterface

interface twrt_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] window_radius;
  modport source (output valid, window_radius, input ready);
  modport sink   (input valid, window_radius, output ready);
endinterface

// ===== design/twrt_cell.sv =====
// One ledger cell: holds one tile entry, trades it with its neighbors.
// Depends on twrt_pkg.
module twrt_cell (
  input  logic              clk,
  input  logic              rst_n,
  input  twrt_pkg::cell_op_t op,
  input  logic [31:0]       key_x,
  input  logic [31:0]       key_z,
  input  logic              new_ld,
  input  logic              new_rb,
  input  twrt_pkg::entry_t  ent_lo,
  input  logic              lt_lo,
  input  twrt_pkg::entry_t  ent_hi,
  output twrt_pkg::entry_t  ent,
  output logic              lt,
  output logic              hit
);

  twrt_pkg::entry_t ent_r;
  twrt_pkg::entry_t ent_nxt;

  assign ent = ent_r;
  assign lt  = ent_r.vld && twrt_pkg::key_less(ent_r.x, ent_r.z, key_x, key_z);
  assign hit = ent_r.vld && (ent_r.x == key_x) && (ent_r.z == key_z);

  always_comb begin
    ent_nxt = ent_r;
    case (op)
      twrt_pkg::OP_CLEAR: begin
        ent_nxt.vld = 1'b0;
        ent_nxt.ld  = 1'b0;
        ent_nxt.rb  = 1'b0;
      end
      twrt_pkg::OP_INSERT: begin
        // sorted insert: smaller keys stay, the rest move up one
        if (!lt) begin
          if (lt_lo) begin
            ent_nxt = '{vld: 1'b1, ld: new_ld, rb: new_rb, x: key_x, z: key_z};
          end else begin
            ent_nxt = ent_lo;
          end
        end
      end
      twrt_pkg::OP_REMOVE: begin
        if (!lt) ent_nxt = ent_hi;
      end
      twrt_pkg::OP_ROTATE: ent_nxt = ent_hi;
      twrt_pkg::OP_SET_LD: begin
        if (hit) ent_nxt.ld = 1'b1;
      end
      twrt_pkg::OP_SET_RB: begin
        if (hit) ent_nxt.rb = 1'b1;
      end
      default: ent_nxt = ent_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_r.vld <= 1'b0;
      ent_r.ld  <= 1'b0;
      ent_r.rb  <= 1'b0;
    end else begin
      ent_r <= ent_nxt;
    end
  end

endmodule

// ===== design/twrt_chain.sv =====
// Row of ledger cells kept sorted by (x, z), packed at the bottom.
// Depends on twrt_pkg and twrt_cell.
module twrt_chain (
  input  logic              clk,
  input  logic              rst_n,
  input  twrt_pkg::cell_op_t op,
  input  logic [31:0]       key_x,
  input  logic [31:0]       key_z,
  input  logic              new_ld,
  input  logic              new_rb,
  output twrt_pkg::entry_t  head,
  output logic              any_hit,
  output logic              hit_ld
);

  localparam int N = twrt_pkg::LEDGER_ENTRIES;

  twrt_pkg::entry_t e  [N];
  twrt_pkg::entry_t lo [N];
  twrt_pkg::entry_t hi [N];
  logic [N-1:0] lt;
  logic [N-1:0] lt_lo;
  logic [N-1:0] hit;
  logic [N-1:0] hit_l;

  for (genvar i = 0; i < N; i++) begin : g_cell
    if (i == 0) begin : g_first
      assign lo[i]    = '0;
      assign lt_lo[i] = 1'b1;
    end else begin : g_mid
      assign lo[i]    = e[i-1];
      assign lt_lo[i] = lt[i-1];
    end
    if (i == N - 1) begin : g_top
      // top closes the ring when rotating, refills empty on remove
      assign hi[i] = (op == twrt_pkg::OP_ROTATE) ? e[0] : '0;
    end else begin : g_low
      assign hi[i] = e[i+1];
    end
    assign hit_l[i] = hit[i] & e[i].ld;

    twrt_cell u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .op     (op),
      .key_x  (key_x),
      .key_z  (key_z),
      .new_ld (new_ld),
      .new_rb (new_rb),
      .ent_lo (lo[i]),
      .lt_lo  (lt_lo[i]),
      .ent_hi (hi[i]),
      .ent    (e[i]),
      .lt     (lt[i]),
      .hit    (hit[i])
    );
  end

  assign head    = e[0];
  assign any_hit = |hit;
  assign hit_ld  = |hit_l;

endmodule

// ===== design/tile_window_residency_tracker_top.sv =====
// Top level of the tile window residency tracker: command sequencer over the cell row.
// Depends on twrt_pkg, twrt_ifs and twrt_chain.
//
//   channel  | dir | beat carries
//   in_ch    | in  | cmd, tile_x, tile_z
//   out_ch   | out | status, answer, out_x, out_z, item_valid, last, loaded_tiles
//   cfg_ch   | in  | window_radius (always ready)
//
// A plain command steps through accept, ledger lookup and result.
// Unload/rebuild lists rotate the whole cell row once.
// Load list walks the (2r+1)^2 window one tile a cycle unless out_ch stalls it.
// Stalled out_ch holds the sequencer if it must emit; reset clears the ledger at once.
module tile_window_residency_tracker_top (
  input logic        clk,
  input logic        rst_n,
  twrt_in_if.sink    in_ch,
  twrt_out_if.source out_ch,
  twrt_cfg_if.sink   cfg_ch
);

  localparam int N = twrt_pkg::LEDGER_ENTRIES;
  localparam int W = twrt_pkg::CNT_W;

  typedef enum logic [2:0] {S_IDLE, S_LOOK, S_EXEC, S_SCAN, S_WIN, S_FIN} state_t;

  state_t      state_r, state_nxt;
  logic [3:0]  cmd_r, cmd_nxt;
  logic [31:0] x_r, x_nxt, z_r, z_nxt;
  logic [31:0] fx_r, fx_nxt, fz_r, fz_nxt;
  logic [1:0]  rad_r, rad_nxt;
  logic [W-1:0] total_r, total_nxt, loaded_r, loaded_nxt;
  logic        hit_r, hit_nxt, hitld_r, hitld_nxt;
  logic [twrt_pkg::IDX_W-1:0] cnt_r, cnt_nxt;
  logic        held_v_r, held_v_nxt;
  logic [31:0] held_x_r, held_x_nxt, held_z_r, held_z_nxt;
  logic signed [2:0] ox_r, ox_nxt, oz_r, oz_nxt;
  logic [31:0] wx_r, wx_nxt, wz_r, wz_nxt;

  logic        o_valid_r, o_valid_nxt;
  logic [1:0]  o_status_r, o_status_nxt;
  logic        o_answer_r, o_answer_nxt;
  logic [31:0] o_x_r, o_x_nxt, o_z_r, o_z_nxt;
  logic        o_iv_r, o_iv_nxt, o_last_r, o_last_nxt;
  logic [6:0]  o_lc_r, o_lc_nxt;

  twrt_pkg::cell_op_t op;
  logic        new_ld, new_rb;
  logic [31:0] key_x, key_z;
  twrt_pkg::entry_t head;
  logic        any_hit, hit_ld;

  logic        can_emit, act_in, head_act, pick, advance;
  logic signed [2:0] rs;

  assign rs       = $signed({1'b0, rad_r});
  assign can_emit = !o_valid_r || out_ch.ready;
  assign act_in   = twrt_pkg::tile_active(x_r, z_r, fx_r, fz_r, rad_r);
  assign head_act = twrt_pkg::tile_active(head.x, head.z, fx_r, fz_r, rad_r);
  assign key_x    = (state_r == S_WIN) ? wx_r : x_r;
  assign key_z    = (state_r == S_WIN) ? wz_r : z_r;

  assign in_ch.ready  = (state_r == S_IDLE);
  assign cfg_ch.ready = 1'b1;

  assign out_ch.valid        = o_valid_r;
  assign out_ch.status       = o_status_r;
  assign out_ch.answer       = o_answer_r;
  assign out_ch.out_x        = o_x_r;
  assign out_ch.out_z        = o_z_r;
  assign out_ch.item_valid   = o_iv_r;
  assign out_ch.last         = o_last_r;
  assign out_ch.loaded_tiles = o_lc_r;

  twrt_chain u_chain (
    .clk     (clk),
    .rst_n   (rst_n),
    .op      (op),
    .key_x   (key_x),
    .key_z   (key_z),
    .new_ld  (new_ld),
    .new_rb  (new_rb),
    .head    (head),
    .any_hit (any_hit),
    .hit_ld  (hit_ld)
  );

  // list pick for the tile currently under inspection
  always_comb begin
    if (state_r == S_WIN) begin
      pick = !hit_ld;
    end else if (cmd_r == twrt_pkg::CMD_LIST_REBUILD) begin
      pick = head.vld && head.ld && head.rb && head_act;
    end else begin
      pick = head.vld && head.ld && !head_act;
    end
  end
  assign advance = !(pick && held_v_r) || can_emit;

  always_comb begin
    state_nxt  = state_r;
    cmd_nxt    = cmd_r;
    x_nxt      = x_r;
    z_nxt      = z_r;
    fx_nxt     = fx_r;
    fz_nxt     = fz_r;
    rad_nxt    = rad_r;
    total_nxt  = total_r;
    loaded_nxt = loaded_r;
    hit_nxt    = hit_r;
    hitld_nxt  = hitld_r;
    cnt_nxt    = cnt_r;
    held_v_nxt = held_v_r;
    held_x_nxt = held_x_r;
    held_z_nxt = held_z_r;
    ox_nxt     = ox_r;
    oz_nxt     = oz_r;
    wx_nxt     = wx_r;
    wz_nxt     = wz_r;
    op         = twrt_pkg::OP_HOLD;
    new_ld     = 1'b0;
    new_rb     = 1'b0;

    o_valid_nxt  = o_valid_r && !out_ch.ready;
    o_status_nxt = o_status_r;
    o_answer_nxt = o_answer_r;
    o_x_nxt      = o_x_r;
    o_z_nxt      = o_z_r;
    o_iv_nxt     = o_iv_r;
    o_last_nxt   = o_last_r;
    o_lc_nxt     = o_lc_r;

    case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          cmd_nxt   = in_ch.cmd;
          x_nxt     = in_ch.tile_x;
          z_nxt     = in_ch.tile_z;
          state_nxt = S_LOOK;
        end
      end
      S_LOOK: begin
        hit_nxt   = any_hit;
        hitld_nxt = hit_ld;
        state_nxt = S_EXEC;
      end
      S_EXEC: begin
        if (can_emit) begin
          o_status_nxt = twrt_pkg::ST_OK;
          o_answer_nxt = 1'b0;
          o_x_nxt      = '0;
          o_z_nxt      = '0;
          o_iv_nxt     = 1'b0;
          o_last_nxt   = 1'b1;
          state_nxt    = S_IDLE;
          case (cmd_r)
            twrt_pkg::CMD_SET_FOCUS: begin
              fx_nxt = x_r;
              fz_nxt = z_r;
            end
            twrt_pkg::CMD_READ_FOCUS: begin
              o_x_nxt = fx_r;
              o_z_nxt = fz_r;
            end
            twrt_pkg::CMD_IS_ACTIVE: o_answer_nxt = act_in;
            twrt_pkg::CMD_IS_LOADED: o_answer_nxt = hitld_r;
            twrt_pkg::CMD_MARK_LOADED, twrt_pkg::CMD_INVALIDATE: begin
              if (!act_in) begin
                o_status_nxt = twrt_pkg::ST_OUTSIDE;
              end else if (hit_r) begin
                o_answer_nxt = 1'b1;
                if (cmd_r == twrt_pkg::CMD_MARK_LOADED) begin
                  op = twrt_pkg::OP_SET_LD;
                  if (!hitld_r) loaded_nxt = loaded_r + W'(1);
                end else begin
                  op = twrt_pkg::OP_SET_RB;
                end
              end else if (total_r == W'(N)) begin
                o_status_nxt = twrt_pkg::ST_FULL;
              end else begin
                o_answer_nxt = 1'b1;
                op           = twrt_pkg::OP_INSERT;
                new_ld       = (cmd_r == twrt_pkg::CMD_MARK_LOADED);
                new_rb       = (cmd_r == twrt_pkg::CMD_INVALIDATE);
                total_nxt    = total_r + W'(1);
                if (new_ld) loaded_nxt = loaded_r + W'(1);
              end
            end
            twrt_pkg::CMD_MARK_UNLOAD: begin
              if (!hitld_r) begin
                o_status_nxt = twrt_pkg::ST_NOT_LOADED;
              end else begin
                // unload clears both marks, so the entry always drops
                o_answer_nxt = 1'b1;
                op           = twrt_pkg::OP_REMOVE;
                total_nxt    = total_r - W'(1);
                loaded_nxt   = loaded_r - W'(1);
              end
            end
            twrt_pkg::CMD_LIST_LOAD: begin
              o_valid_nxt = o_valid_r && !out_ch.ready;
              held_v_nxt  = 1'b0;
              ox_nxt      = -rs;
              oz_nxt      = -rs;
              wx_nxt      = fx_r - {30'd0, rad_r};
              wz_nxt      = fz_r - {30'd0, rad_r};
              state_nxt   = S_WIN;
            end
            twrt_pkg::CMD_LIST_UNLOAD, twrt_pkg::CMD_LIST_REBUILD: begin
              o_valid_nxt = o_valid_r && !out_ch.ready;
              held_v_nxt  = 1'b0;
              cnt_nxt     = '0;
              state_nxt   = S_SCAN;
            end
            twrt_pkg::CMD_CLEAR: begin
              op         = twrt_pkg::OP_CLEAR;
              total_nxt  = '0;
              loaded_nxt = '0;
              fx_nxt     = '0;
              fz_nxt     = '0;
            end
            default: ;
          endcase
          if (cmd_r != twrt_pkg::CMD_LIST_LOAD && cmd_r != twrt_pkg::CMD_LIST_UNLOAD &&
              cmd_r != twrt_pkg::CMD_LIST_REBUILD) begin
            o_valid_nxt = 1'b1;
            o_lc_nxt    = 7'(loaded_nxt);
          end
        end
      end
      S_SCAN, S_WIN: begin
        if (advance) begin
          // one-deep hold so the final listed tile can carry last
          if (pick) begin
            if (held_v_r) begin
              o_valid_nxt  = 1'b1;
              o_status_nxt = twrt_pkg::ST_OK;
              o_answer_nxt = 1'b0;
              o_x_nxt      = held_x_r;
              o_z_nxt      = held_z_r;
              o_iv_nxt     = 1'b1;
              o_last_nxt   = 1'b0;
              o_lc_nxt     = 7'(loaded_r);
            end
            held_v_nxt = 1'b1;
            held_x_nxt = (state_r == S_WIN) ? wx_r : head.x;
            held_z_nxt = (state_r == S_WIN) ? wz_r : head.z;
          end
          if (state_r == S_SCAN) begin
            op      = twrt_pkg::OP_ROTATE;
            cnt_nxt = cnt_r + twrt_pkg::IDX_W'(1);
            if (cnt_r == twrt_pkg::IDX_W'(N - 1)) state_nxt = S_FIN;
          end else begin
            if (oz_r == rs) begin
              oz_nxt = -rs;
              wz_nxt = fz_r - {30'd0, rad_r};
              ox_nxt = ox_r + 3'sd1;
              wx_nxt = wx_r + 32'd1;
              if (ox_r == rs) state_nxt = S_FIN;
            end else begin
              oz_nxt = oz_r + 3'sd1;
              wz_nxt = wz_r + 32'd1;
            end
          end
        end
      end
      S_FIN: begin
        if (can_emit) begin
          o_valid_nxt  = 1'b1;
          o_status_nxt = twrt_pkg::ST_OK;
          o_answer_nxt = 1'b0;
          o_x_nxt      = held_v_r ? held_x_r : 32'd0;
          o_z_nxt      = held_v_r ? held_z_r : 32'd0;
          o_iv_nxt     = held_v_r;
          o_last_nxt   = 1'b1;
          o_lc_nxt     = 7'(loaded_r);
          held_v_nxt   = 1'b0;
          state_nxt    = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase

    // radius write: zero is ignored, larger values clamp
    if (cfg_ch.valid && cfg_ch.window_radius != 2'd0) begin
      rad_nxt    = (cfg_ch.window_radius > 2'(twrt_pkg::RADIUS_MAX)) ?
                   2'(twrt_pkg::RADIUS_MAX) : cfg_ch.window_radius;
      op         = twrt_pkg::OP_CLEAR;
      total_nxt  = '0;
      loaded_nxt = '0;
      fx_nxt     = '0;
      fz_nxt     = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      fx_r      <= '0;
      fz_r      <= '0;
      rad_r     <= 2'd1;
      total_r   <= '0;
      loaded_r  <= '0;
      held_v_r  <= 1'b0;
      o_valid_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      fx_r      <= fx_nxt;
      fz_r      <= fz_nxt;
      rad_r     <= rad_nxt;
      total_r   <= total_nxt;
      loaded_r  <= loaded_nxt;
      held_v_r  <= held_v_nxt;
      o_valid_r <= o_valid_nxt;
    end
    cmd_r      <= cmd_nxt;
    x_r        <= x_nxt;
    z_r        <= z_nxt;
    hit_r      <= hit_nxt;
    hitld_r    <= hitld_nxt;
    cnt_r      <= cnt_nxt;
    held_x_r   <= held_x_nxt;
    held_z_r   <= held_z_nxt;
    ox_r       <= ox_nxt;
    oz_r       <= oz_nxt;
    wx_r       <= wx_nxt;
    wz_r       <= wz_nxt;
    o_status_r <= o_status_nxt;
    o_answer_r <= o_answer_nxt;
    o_x_r      <= o_x_nxt;
    o_z_r      <= o_z_nxt;
    o_iv_r     <= o_iv_nxt;
    o_last_r   <= o_last_nxt;
    o_lc_r     <= o_lc_nxt;
  end

  a_loaded_le_total: assert property (@(posedge clk) disable iff (!rst_n)
    loaded_r <= total_r) else $error("loaded count above entry count");

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= W'(N)) else $error("entry count above ledger size");

  a_cfg_wipes: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_ch.valid && (cfg_ch.window_radius != 2'd0) |=> (total_r == '0) && (fx_r == '0))
    else $error("radius write did not clear ledger");

endmodule

// ===== dv/twrt_checker.sv =====
// Checker for the tile window residency tracker: watches in, out and cfg beats,
// predicts every result beat and compares field by field.
// Depends on twrt_pkg and twrt_ifs.
module twrt_checker (
  input  logic      clk,
  input  logic      rst_n,
  twrt_in_if.sink   in_mon,
  twrt_out_if.sink  out_mon,
  twrt_cfg_if.sink  cfg_mon,
  output int        fail_count,
  output int        pending,
  output int        beats_seen
);

  typedef struct packed {
    logic [1:0]  status;
    logic        answer;
    logic [31:0] x;
    logic [31:0] z;
    logic        item_valid;
    logic        last;
    logic [6:0]  loaded_tiles;
  } beat_t;

  beat_t       expected_beats[$];
  logic [31:0] focus_x, focus_z;
  logic [1:0]  radius;
  logic [31:0] led_x[twrt_pkg::LEDGER_ENTRIES];
  logic [31:0] led_z[twrt_pkg::LEDGER_ENTRIES];
  logic        led_ld[twrt_pkg::LEDGER_ENTRIES];
  logic        led_rb[twrt_pkg::LEDGER_ENTRIES];
  int          led_total;

  assign pending = expected_beats.size();

  function automatic longint sext(logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic bit in_window(logic [31:0] x, logic [31:0] z);
    longint dx, dz, r;
    dx = sext(x) - sext(focus_x);
    dz = sext(z) - sext(focus_z);
    r = radius;
    return dx >= -r && dx <= r && dz >= -r && dz <= r;
  endfunction

  function automatic int lookup(logic [31:0] x, logic [31:0] z);
    for (int i = 0; i < led_total; i++)
      if (led_x[i] == x && led_z[i] == z) return i;
    return -1;
  endfunction

  function automatic bit tile_before(int a, int b);
    if (led_x[a] != led_x[b]) return sext(led_x[a]) < sext(led_x[b]);
    return sext(led_z[a]) < sext(led_z[b]);
  endfunction

  task automatic wipe_ledger();
    for (int i = 0; i < twrt_pkg::LEDGER_ENTRIES; i++) begin
      led_ld[i] = 0;
      led_rb[i] = 0;
    end
    led_total = 0;
    focus_x = 0;
    focus_z = 0;
  endtask

  task automatic predict(logic [3:0] cmd, logic [31:0] x, logic [31:0] z);
    beat_t b;
    beat_t res[$];
    int e, cnt;
    int picks[$];
    longint r;
    bit sel;
    b = '0;
    case (cmd)
      twrt_pkg::CMD_SET_FOCUS: begin
        focus_x = x;
        focus_z = z;
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_READ_FOCUS: begin
        b.x = focus_x;
        b.z = focus_z;
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_IS_ACTIVE: begin
        b.answer = in_window(x, z);
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_IS_LOADED: begin
        e = lookup(x, z);
        b.answer = (e >= 0) && led_ld[e];
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_MARK_LOADED, twrt_pkg::CMD_INVALIDATE: begin
        if (!in_window(x, z)) b.status = twrt_pkg::ST_OUTSIDE;
        else begin
          e = lookup(x, z);
          if (e < 0 && led_total < twrt_pkg::LEDGER_ENTRIES) begin
            e = led_total;
            led_x[e] = x;
            led_z[e] = z;
            led_ld[e] = 0;
            led_rb[e] = 0;
            led_total++;
          end
          if (e < 0) b.status = twrt_pkg::ST_FULL;
          else begin
            if (cmd == twrt_pkg::CMD_MARK_LOADED) led_ld[e] = 1;
            else led_rb[e] = 1;
            b.answer = 1;
          end
        end
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_MARK_UNLOAD: begin
        e = lookup(x, z);
        if (e < 0 || !led_ld[e]) b.status = twrt_pkg::ST_NOT_LOADED;
        else begin
          led_ld[e] = 0;
          led_rb[e] = 0;
          // freed slot gets the top entry
          led_total--;
          led_x[e] = led_x[led_total];
          led_z[e] = led_z[led_total];
          led_ld[e] = led_ld[led_total];
          led_rb[e] = led_rb[led_total];
          led_ld[led_total] = 0;
          led_rb[led_total] = 0;
          b.answer = 1;
        end
        res.insert(res.size(), b);
      end
      twrt_pkg::CMD_LIST_LOAD: begin
        r = radius;
        for (longint a = sext(focus_x) - r; a <= sext(focus_x) + r; a++)
          for (longint c = sext(focus_z) - r; c <= sext(focus_z) + r; c++) begin
            e = lookup(a[31:0], c[31:0]);
            if (e < 0 || !led_ld[e]) begin
              b = '0;
              b.x = a[31:0];
              b.z = c[31:0];
              b.item_valid = 1;
              res.insert(res.size(), b);
            end
          end
        if (res.size() == 0) res.insert(0, b);
      end
      twrt_pkg::CMD_LIST_UNLOAD, twrt_pkg::CMD_LIST_REBUILD: begin
        for (int i = 0; i < led_total; i++) begin
          if (cmd == twrt_pkg::CMD_LIST_REBUILD)
            sel = led_rb[i] && led_ld[i] && in_window(led_x[i], led_z[i]);
          else
            sel = led_ld[i] && !in_window(led_x[i], led_z[i]);
          if (sel) begin
            int j;
            j = picks.size();
            picks.insert(j, i);
            while (j > 0 && tile_before(i, picks[j-1])) begin
              picks[j] = picks[j-1];
              j--;
            end
            picks[j] = i;
          end
        end
        foreach (picks[k]) begin
          b = '0;
          b.x = led_x[picks[k]];
          b.z = led_z[picks[k]];
          b.item_valid = 1;
          res.insert(res.size(), b);
        end
        if (res.size() == 0) res.insert(0, b);
      end
      twrt_pkg::CMD_CLEAR: begin
        wipe_ledger();
        res.insert(res.size(), b);
      end
      default: res.insert(res.size(), b);
    endcase
    cnt = 0;
    for (int i = 0; i < led_total; i++) if (led_ld[i]) cnt++;
    foreach (res[k]) begin
      res[k].loaded_tiles = 7'(cnt);
      res[k].last = (k == res.size() - 1);
      expected_beats.insert(expected_beats.size(), res[k]);
    end
  endtask

  always @(posedge clk) begin
    beat_t got, want;
    if (!rst_n) begin
      wipe_ledger();
      radius = 1;
      expected_beats.delete();
      fail_count <= 0;
      beats_seen <= 0;
    end else begin
      if (cfg_mon.valid && cfg_mon.ready && cfg_mon.window_radius != 0) begin
        radius = (cfg_mon.window_radius > twrt_pkg::RADIUS_MAX) ?
                 2'(twrt_pkg::RADIUS_MAX) : cfg_mon.window_radius;
        wipe_ledger();
      end
      if (out_mon.valid && out_mon.ready) begin
        got = {out_mon.status, out_mon.answer, out_mon.out_x, out_mon.out_z,
               out_mon.item_valid, out_mon.last, out_mon.loaded_tiles};
        beats_seen <= beats_seen + 1;
        if (expected_beats.size() == 0) begin
          $display("%0t: result beat with none expected: %h", $time, got);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_beats.pop_front();
          if (got !== want) begin
            $display("%0t: mismatch expected st=%0d ans=%0d x=%h z=%h iv=%0d last=%0d lc=%0d",
                     $time, want.status, want.answer, want.x, want.z, want.item_valid,
                     want.last, want.loaded_tiles);
            $display("%0t:          actual   st=%0d ans=%0d x=%h z=%h iv=%0d last=%0d lc=%0d",
                     $time, got.status, got.answer, got.x, got.z, got.item_valid,
                     got.last, got.loaded_tiles);
            fail_count <= fail_count + 1;
          end
        end
      end
      if (in_mon.valid && in_mon.ready)
        predict(in_mon.cmd, in_mon.tile_x, in_mon.tile_z);
    end
  end
endmodule

// ===== dv/tile_window_residency_tracker_top_tb.sv =====
// Testbench top of the tile window residency tracker: clock, reset, command
// stimulus with bursts and stalls, radius changes, verdict.
// Depends on twrt_pkg, twrt_ifs, the block and twrt_checker.
module tile_window_residency_tracker_top_tb;

  logic clk = 0;
  logic rst_n = 0;
  int   fail_count, pending, beats_seen;
  int   cmds_sent = 0;
  bit   long_hold = 0;
  logic [31:0] fx = 0, fz = 0;
  logic [1:0]  cur_radius = 1;

  twrt_in_if  in_ch();
  twrt_out_if out_ch();
  twrt_cfg_if cfg_ch();

  tile_window_residency_tracker_top uut (.clk(clk), .rst_n(rst_n), .in_ch(in_ch),
                                         .out_ch(out_ch), .cfg_ch(cfg_ch));
  twrt_checker chk (.clk(clk), .rst_n(rst_n), .in_mon(in_ch), .out_mon(out_ch),
                    .cfg_mon(cfg_ch), .fail_count(fail_count), .pending(pending),
                    .beats_seen(beats_seen));

  always #4 clk = ~clk;

  // receiver stall pattern; a long hold is forced once from the stimulus side
  always @(posedge clk) begin
    if (!rst_n || long_hold) out_ch.ready <= 0;
    else case ($urandom_range(0, 3))
      0: out_ch.ready <= 1;
      1: out_ch.ready <= ($urandom_range(0, 3) != 0);
      2: out_ch.ready <= ($urandom_range(0, 1) == 0);
      default: out_ch.ready <= 1;
    endcase
  end

  task automatic send(logic [3:0] cmd, logic [31:0] x, logic [31:0] z);
    in_ch.valid <= 1;
    in_ch.cmd <= cmd;
    in_ch.tile_x <= x;
    in_ch.tile_z <= z;
    do @(posedge clk); while (!in_ch.ready);
    cmds_sent++;
  endtask

  task automatic gap(int n);
    if (n > 0) begin
      in_ch.valid <= 0;
      repeat (n) @(posedge clk);
    end
  endtask

  task automatic drain();
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_radius(logic [1:0] r);
    drain();
    cfg_ch.valid <= 1;
    cfg_ch.window_radius <= r;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 0;
    if (r != 0) begin
      cur_radius = (r > twrt_pkg::RADIUS_MAX) ? 2'(twrt_pkg::RADIUS_MAX) : r;
      fx = 0;
      fz = 0;
    end
  endtask

  function automatic logic [31:0] near(logic [31:0] c);
    return c + $urandom_range(0, 2 * cur_radius + 2) - cur_radius - 1;
  endfunction

  // mostly window-relative commands, some wild coordinates
  task automatic random_cmd();
    logic [3:0] cmd;
    logic [31:0] x, z;
    int p;
    p = $urandom_range(0, 99);
    if (p < 30) cmd = twrt_pkg::CMD_MARK_LOADED;
    else if (p < 40) cmd = twrt_pkg::CMD_INVALIDATE;
    else if (p < 50) cmd = twrt_pkg::CMD_MARK_UNLOAD;
    else if (p < 56) cmd = twrt_pkg::CMD_SET_FOCUS;
    else if (p < 62) cmd = twrt_pkg::CMD_IS_LOADED;
    else if (p < 68) cmd = twrt_pkg::CMD_IS_ACTIVE;
    else if (p < 74) cmd = twrt_pkg::CMD_LIST_UNLOAD;
    else if (p < 80) cmd = twrt_pkg::CMD_LIST_REBUILD;
    else if (p < 85) cmd = twrt_pkg::CMD_LIST_LOAD;
    else if (p < 88) cmd = twrt_pkg::CMD_READ_FOCUS;
    else if (p < 89) cmd = twrt_pkg::CMD_CLEAR;
    else if (p < 91) cmd = 4'($urandom_range(11, 15));
    else cmd = 4'($urandom_range(0, 15));
    if ($urandom_range(0, 9) == 0) begin
      x = $urandom;
      z = $urandom;
    end else begin
      x = near(fx);
      z = near(fz);
    end
    if (cmd == twrt_pkg::CMD_SET_FOCUS) begin
      if ($urandom_range(0, 2) == 0) begin
        x = fx + $urandom_range(0, 6) - 3;
        z = fz + $urandom_range(0, 6) - 3;
      end
      fx = x;
      fz = z;
    end else if (cmd == twrt_pkg::CMD_CLEAR) begin
      fx = 0;
      fz = 0;
    end
    send(cmd, x, z);
  endtask

  initial begin
    in_ch.valid <= 0;
    in_ch.cmd <= 0;
    in_ch.tile_x <= 0;
    in_ch.tile_z <= 0;
    cfg_ch.valid <= 0;
    cfg_ch.window_radius <= 0;
    repeat (4) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed: every command, field extremes, window edges, wrap
    send(twrt_pkg::CMD_READ_FOCUS, 0, 0);
    send(twrt_pkg::CMD_IS_ACTIVE, 1, -1);
    send(twrt_pkg::CMD_IS_ACTIVE, 2, 0);
    send(twrt_pkg::CMD_MARK_LOADED, 2, 0);
    send(twrt_pkg::CMD_INVALIDATE, -1, 1);
    send(twrt_pkg::CMD_MARK_UNLOAD, 5, 5);
    send(twrt_pkg::CMD_MARK_LOADED, 1, 1);
    send(twrt_pkg::CMD_MARK_LOADED, -1, 1);
    send(twrt_pkg::CMD_INVALIDATE, 1, 1);
    send(twrt_pkg::CMD_IS_LOADED, 1, 1);
    send(twrt_pkg::CMD_LIST_LOAD, 0, 0);
    send(twrt_pkg::CMD_LIST_REBUILD, 0, 0);
    send(twrt_pkg::CMD_SET_FOCUS, 32'h7fff_ffff, 32'h8000_0000);
    send(twrt_pkg::CMD_READ_FOCUS, 0, 0);
    send(twrt_pkg::CMD_LIST_UNLOAD, 0, 0);
    send(twrt_pkg::CMD_MARK_LOADED, 32'h7fff_fffe, 32'h8000_0001);
    send(twrt_pkg::CMD_LIST_LOAD, 32'hffff_ffff, 32'hffff_ffff);
    send(twrt_pkg::CMD_MARK_UNLOAD, 1, 1);
    send(twrt_pkg::CMD_MARK_UNLOAD, 1, 1);
    send(twrt_pkg::CMD_IS_LOADED, 32'h7fff_fffe, 32'h8000_0001);
    send(4'd15, 32'hffff_ffff, 32'hffff_ffff);
    send(4'd11, 0, 0);
    send(twrt_pkg::CMD_CLEAR, 0, 0);
    send(twrt_pkg::CMD_LIST_UNLOAD, 0, 0);
    fx = 0; fz = 0;

    // radius 3, fill the ledger past capacity: 49 in window, then walk the focus
    write_radius(2'd3);
    for (int i = 0; i < 70; i++) begin
      if (i == 49) send(twrt_pkg::CMD_SET_FOCUS, 10, 0);
      if (i < 49) send(twrt_pkg::CMD_MARK_LOADED, i / 7 - 3, i % 7 - 3);
      else send(i[0] ? twrt_pkg::CMD_INVALIDATE : twrt_pkg::CMD_MARK_LOADED,
                10 + (i % 7) - 3, (i / 7) % 7 - 3);
    end
    send(twrt_pkg::CMD_LIST_UNLOAD, 0, 0);
    send(twrt_pkg::CMD_LIST_LOAD, 0, 0);

    // long receiver hold while commands keep coming
    long_hold = 1;
    fork
      begin
        for (int i = 0; i < 12; i++) send(twrt_pkg::CMD_IS_ACTIVE, i, -i);
      end
      begin
        repeat (150) @(posedge clk);
        long_hold = 0;
      end
    join
    in_ch.valid <= 0;

    // random phases over several radius settings, zero write included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        1: write_radius(2'd0);
        2: write_radius(2'd1);
        3: write_radius(2'd2);
        4: write_radius(2'd3);
        5: write_radius(2'd1);
        default: ;
      endcase
      for (int i = 0; i < 65; ) begin
        int burst;
        burst = $urandom_range(1, 12);
        for (int k = 0; k < burst; k++, i++) random_cmd();
        if ($urandom_range(0, 3) != 0) gap($urandom_range(1, 10));
        if (i > 30 && i < 43) begin
          drain();
          i = 43;
        end
      end
    end
    in_ch.valid <= 0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    $display("run: %0d commands sent, %0d result beats checked, radii 1..3 and a zero write.",
             cmds_sent, beats_seen);
    if (fail_count == 0 && pending == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  initial begin
    #4000000;
    $display("timeout after %0d commands, %0d pending", cmds_sent, pending);
    $display("status: fail");
    $finish;
  end
endmodule
